// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define LLWA_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llwa: same-cycle check failed");

// Next-cycle implication checked on every rising edge outside reset.
`define LLWA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llwa: next-cycle check failed");

`endif

// File: hdl/llwa_pkg.sv
package llwa_pkg;

  localparam int KEY_FIELD_BITS = 32;
  localparam int MAXW_BITS = 4;
  localparam logic [MAXW_BITS-1:0] MAXW_RESET = 4'd4;
  localparam int LOAD_BITS = 7;
  localparam logic [LOAD_BITS-1:0] LOAD_MAX = 7'd127;
  localparam int WIDX_OUT_BITS = 3;

  localparam logic REQ_ASSIGN = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_HELD     = 3'd2,
    ST_NOT_HELD = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_req;
    logic cnt_clr;
    logic cnt_inc;
    logic clr_wr;
    logic scan_en;
    logic decide;
    logic commit;
    logic load_rsp;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic rsp_free;
  } stat_t;

endpackage

// File: hdl/llwa_req_if.sv
interface llwa_req_if;
  import llwa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [KEY_FIELD_BITS-1:0] object_key;

  modport source (output valid, req_type, object_key, input ready);
  modport sink (input valid, req_type, object_key, output ready);
endinterface

// File: hdl/llwa_rsp_if.sv
interface llwa_rsp_if;
  import llwa_pkg::*;

  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic [WIDX_OUT_BITS-1:0] worker_index;
  logic                     worker_opened;
  logic                     worker_retired;

  modport source (output valid, status, worker_index, worker_opened, worker_retired,
                  input ready);
  modport sink (input valid, status, worker_index, worker_opened, worker_retired,
                output ready);
endinterface

// File: hdl/least_loaded_worker_assigner_core.sv
// Channel   Dir   Handshake       Payload
// req       in    valid / ready   req_type, object_key
// rsp       out   valid / ready   status, worker_index, worker_opened, worker_retired
// cfg       in    cfg_we          cfg_wdata (max_workers)
//
// Each request makes one sequential pass over the object table memory, one entry per cycle,
// that also walks the worker pool.
// After reset a clearing pass over every entry empties the object table; req is not ready
// during it, while configuration writes are taken.
// A result that is not taken stays in the output register; the next request is accepted
// meanwhile and its result waits until that register is free.
module least_loaded_worker_assigner_core #(
  parameter int WORKERS  = 8,
  parameter int OBJECTS  = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [llwa_pkg::MAXW_BITS-1:0] cfg_wdata,
  llwa_req_if.sink                       req,
  llwa_rsp_if.source                     rsp
);
  import llwa_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  req_ready;

  assign req.ready = req_ready;

  llwa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  llwa_dp #(
    .WORKERS  (WORKERS),
    .OBJECTS  (OBJECTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_type   (req.req_type),
    .object_key (req.object_key),
    .cmd        (cmd),
    .stat       (stat),
    .rsp        (rsp)
  );

endmodule

// File: hdl/llwa_ctrl.sv
`include "assert_macros.svh"

module llwa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  llwa_pkg::stat_t stat,
  output llwa_pkg::cmd_t  cmd
);
  import llwa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DECIDE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // The result register may still hold the previous result.
        if (stat.rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  `LLWA_ASSERT_NEXT(a_accept_scan, clk, rst, req_valid && req_ready, state == S_SCAN)
  `LLWA_ASSERT_NEXT(a_commit_once, clk, rst, cmd.commit, !cmd.commit)
  `LLWA_ASSERT_IMP(a_rsp_room, clk, rst, cmd.load_rsp, stat.rsp_free && state == S_DONE)

endmodule

// File: hdl/llwa_dp.sv
`include "assert_macros.svh"

module llwa_dp #(
  parameter int WORKERS  = 8,
  parameter int OBJECTS  = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [llwa_pkg::MAXW_BITS-1:0]      cfg_wdata,
  input  logic                                req_type,
  input  logic [llwa_pkg::KEY_FIELD_BITS-1:0] object_key,
  input  llwa_pkg::cmd_t                      cmd,
  output llwa_pkg::stat_t                     stat,
  llwa_rsp_if.source                          rsp
);
  import llwa_pkg::*;

  localparam int KW = (KEY_BITS < KEY_FIELD_BITS) ? KEY_BITS : KEY_FIELD_BITS;
  localparam int AW = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;
  localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int NW = $clog2(WORKERS + 1);
  localparam int SCAN_LAST = (OBJECTS > WORKERS) ? OBJECTS : WORKERS;
  localparam int CW = $clog2(SCAN_LAST + 1);
  localparam int LW = (NW > MAXW_BITS) ? NW : MAXW_BITS;

  localparam logic [CW-1:0] OBJ_C  = CW'(OBJECTS);
  localparam logic [CW-1:0] WRK_C  = CW'(WORKERS);
  localparam logic [CW-1:0] LAST_C = CW'(SCAN_LAST);
  localparam logic [CW-1:0] CLR_C  = CW'(OBJECTS - 1);

  typedef struct packed {
    logic          valid;
    logic [KW-1:0] key;
    logic [WW-1:0] worker;
  } entry_t;

  // Configuration.
  logic [MAXW_BITS-1:0] max_workers;

  // Object table and scan counter.
  entry_t        mem [OBJECTS];
  entry_t        rd_entry;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [CW-1:0] cnt, cnt_m1;

  // Worker pool.
  logic [WORKERS-1:0]   worker_active;
  logic [LOAD_BITS-1:0] worker_load [WORKERS];

  // Latched request.
  logic          req_rel;
  logic [KW-1:0] key;

  // Scan results.
  logic                 found, free;
  logic [AW-1:0]        found_idx, free_idx;
  logic [WW-1:0]        found_worker;
  logic [NW-1:0]        act_cnt;
  logic                 inact_ok, min_ok;
  logic [WW-1:0]        inact_idx, min_idx;
  logic [LOAD_BITS-1:0] min_load;
  logic                 obj_chk, wrk_chk;
  logic [WW-1:0]        wi;

  // Decision.
  logic [LW-1:0]        mw_ext, limit;
  logic                 open_ok;
  logic [WW-1:0]        a_w;
  logic [LOAD_BITS-1:0] a_old, a_load, r_old, r_load;
  status_t              status_c;

  status_t              dec_status;
  logic                 dec_assign, dec_opened, dec_retired;
  logic [WW-1:0]        dec_w;
  logic [LOAD_BITS-1:0] dec_load;
  logic [AW-1:0]        dec_slot;

  // Result register.
  logic                     rsp_valid;
  status_t                  rsp_status;
  logic [WIDX_OUT_BITS-1:0] rsp_windex;
  logic                     rsp_opened, rsp_retired;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_workers <= MAXW_RESET;
    end else if (cfg_we) begin
      max_workers <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CW'(1);
    end
  end

  assign cnt_m1 = cnt - CW'(1);

  assign stat.clr_last  = (cnt == CLR_C);
  assign stat.scan_last = (cnt == LAST_C);
  assign stat.rsp_free  = !rsp_valid || rsp.ready;

  always_comb begin
    mem_we    = cmd.clr_wr || (cmd.commit && dec_status == ST_OK);
    mem_waddr = cmd.clr_wr ? cnt[AW-1:0] : dec_slot;
    mem_wdata = '0;
    if (cmd.commit && dec_assign) begin
      mem_wdata.valid  = 1'b1;
      mem_wdata.key    = key;
      mem_wdata.worker = dec_w;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cnt < OBJ_C) begin
      rd_entry <= mem[cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_rel <= (req_type == REQ_RELEASE);
      key     <= object_key[KW-1:0];
    end
  end

  // Read data is registered, so the entry checked at count k is entry k-1.
  assign obj_chk = cmd.scan_en && (cnt != '0) && (cnt <= OBJ_C);
  assign wrk_chk = cmd.scan_en && (cnt < WRK_C);
  assign wi      = cnt[WW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      found    <= 1'b0;
      free     <= 1'b0;
      act_cnt  <= '0;
      inact_ok <= 1'b0;
      min_ok   <= 1'b0;
    end else begin
      if (obj_chk) begin
        if (rd_entry.valid && rd_entry.key == key) begin
          found        <= 1'b1;
          found_idx    <= cnt_m1[AW-1:0];
          found_worker <= rd_entry.worker;
        end
        if (!rd_entry.valid && !free) begin
          free     <= 1'b1;
          free_idx <= cnt_m1[AW-1:0];
        end
      end
      if (wrk_chk) begin
        if (worker_active[wi]) begin
          act_cnt <= act_cnt + NW'(1);
          // Strict compare keeps the lowest index on a tie.
          if (!min_ok || worker_load[wi] < min_load) begin
            min_ok   <= 1'b1;
            min_idx  <= wi;
            min_load <= worker_load[wi];
          end
        end else if (!inact_ok) begin
          inact_ok  <= 1'b1;
          inact_idx <= wi;
        end
      end
    end
  end

  always_comb begin
    mw_ext = LW'(max_workers);
    if (max_workers == '0) begin
      limit = LW'(1);
    end else if (mw_ext > LW'(WORKERS)) begin
      limit = LW'(WORKERS);
    end else begin
      limit = mw_ext;
    end
    open_ok = (LW'(act_cnt) < limit) && inact_ok;
    a_w     = open_ok ? inact_idx : (min_ok ? min_idx : '0);
    a_old   = (open_ok || !min_ok) ? '0 : min_load;
    a_load  = (a_old < LOAD_MAX) ? a_old + LOAD_BITS'(1) : a_old;
    r_old   = worker_load[found_worker];
    r_load  = (r_old != '0) ? r_old - LOAD_BITS'(1) : '0;

    priority if (key == '0) begin
      status_c = ST_NULL;
    end else if (!req_rel && found) begin
      status_c = ST_HELD;
    end else if (!req_rel && !free) begin
      status_c = ST_FULL;
    end else if (req_rel && !found) begin
      status_c = ST_NOT_HELD;
    end else begin
      status_c = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      dec_status  <= status_c;
      dec_assign  <= !req_rel;
      dec_w       <= req_rel ? found_worker : a_w;
      dec_load    <= req_rel ? r_load : a_load;
      dec_slot    <= req_rel ? found_idx : free_idx;
      dec_opened  <= !req_rel && open_ok;
      dec_retired <= req_rel && (r_load == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_active <= '0;
      for (int i = 0; i < WORKERS; i++) begin
        worker_load[i] <= '0;
      end
    end else if (cmd.commit && dec_status == ST_OK) begin
      worker_load[dec_w]   <= dec_load;
      worker_active[dec_w] <= dec_assign || !dec_retired;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp_status  <= dec_status;
      rsp_windex  <= (dec_status == ST_OK) ? WIDX_OUT_BITS'(dec_w) : '0;
      rsp_opened  <= (dec_status == ST_OK) && dec_opened;
      rsp_retired <= (dec_status == ST_OK) && dec_retired;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_status;
  assign rsp.worker_index   = rsp_windex;
  assign rsp.worker_opened  = rsp_opened;
  assign rsp.worker_retired = rsp_retired;

  `LLWA_ASSERT_IMP(a_act_bound, clk, rst, cmd.decide, act_cnt <= NW'(WORKERS))
  `LLWA_ASSERT_IMP(a_load_up, clk, rst, cmd.commit && dec_status == ST_OK && dec_assign, dec_load != '0)
  `LLWA_ASSERT_NEXT(a_rsp_set, clk, rst, cmd.load_rsp, rsp_valid && rsp_status == $past(dec_status))

endmodule

// File: bench/least_loaded_worker_assigner_monitor.sv
`timescale 1ns / 100ps

module least_loaded_worker_assigner_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [llwa_pkg::MAXW_BITS-1:0] cfg_wdata,
  llwa_req_if                            req,
  llwa_rsp_if                            rsp,
  output int                             fail_count,
  output int                             open_items
);
  import llwa_pkg::*;

  localparam int WORKER_SLOTS = 8;
  localparam int TABLE_DEPTH  = 64;

  typedef struct packed {
    status_t                  status;
    logic [WIDX_OUT_BITS-1:0] worker;
    logic                     opened;
    logic                     retired;
  } outcome_t;

  logic [MAXW_BITS-1:0]      worker_cap;
  bit                        worker_busy  [WORKER_SLOTS];
  logic [LOAD_BITS-1:0]      worker_count [WORKER_SLOTS];
  bit                        slot_used    [TABLE_DEPTH];
  logic [KEY_FIELD_BITS-1:0] slot_key     [TABLE_DEPTH];
  int                        slot_owner   [TABLE_DEPTH];
  outcome_t                  pending_outcomes [$];

  // Works out the answer to one request and updates the pool and table.
  function automatic outcome_t assign_or_release(logic kind, logic [KEY_FIELD_BITS-1:0] key);
    outcome_t res;
    int       hit;
    int       free_slot;
    int       pick;
    int       busy_total;
    int       limit;
    res = '{status: ST_OK, worker: '0, opened: 1'b0, retired: 1'b0};
    hit = -1;
    free_slot = -1;
    pick = -1;
    busy_total = 0;
    if (key == '0) begin
      res.status = ST_NULL;
      return res;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
    end
    if (kind == REQ_ASSIGN) begin
      if (hit >= 0) begin
        res.status = ST_HELD;
        return res;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (free_slot < 0 && !slot_used[i]) free_slot = i;
      end
      if (free_slot < 0) begin
        res.status = ST_FULL;
        return res;
      end
      limit = int'(worker_cap);
      if (limit < 1) limit = 1;
      if (limit > WORKER_SLOTS) limit = WORKER_SLOTS;
      for (int i = 0; i < WORKER_SLOTS; i++) begin
        if (worker_busy[i]) busy_total++;
      end
      if (busy_total < limit) begin
        for (int i = 0; i < WORKER_SLOTS; i++) begin
          if (pick < 0 && !worker_busy[i]) pick = i;
        end
        res.opened = (pick >= 0);
      end
      // Least loaded active worker; strict compare keeps the lowest index on ties.
      if (pick < 0) begin
        for (int i = 0; i < WORKER_SLOTS; i++) begin
          if (worker_busy[i] && (pick < 0 || worker_count[i] < worker_count[pick])) pick = i;
        end
      end
      if (pick < 0) pick = 0;
      if (res.opened) begin
        worker_busy[pick] = 1'b1;
        worker_count[pick] = '0;
      end
      if (worker_count[pick] != LOAD_MAX) worker_count[pick] = worker_count[pick] + 1'b1;
      slot_used[free_slot] = 1'b1;
      slot_key[free_slot] = key;
      slot_owner[free_slot] = pick;
      res.worker = pick[WIDX_OUT_BITS-1:0];
    end else begin
      if (hit < 0) begin
        res.status = ST_NOT_HELD;
        return res;
      end
      pick = slot_owner[hit];
      if (worker_count[pick] != '0) worker_count[pick] = worker_count[pick] - 1'b1;
      slot_used[hit] = 1'b0;
      if (worker_count[pick] == '0) begin
        worker_busy[pick] = 1'b0;
        res.retired = 1'b1;
      end
      res.worker = pick[WIDX_OUT_BITS-1:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      worker_cap = MAXW_RESET;
      for (int i = 0; i < WORKER_SLOTS; i++) begin
        worker_busy[i] = 1'b0;
        worker_count[i] = '0;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_used[i] = 1'b0;
        slot_key[i] = '0;
        slot_owner[i] = 0;
      end
      pending_outcomes.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) worker_cap = cfg_wdata;
      // The result side is handled first: a result can never belong to a request
      // accepted at the same edge.
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) begin
          $error("result with nothing pending: status %0d, worker %0d",
                 rsp.status, rsp.worker_index);
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.worker_index !== want.worker) begin
            $error("worker_index: expected %0d, got %0d", want.worker, rsp.worker_index);
            fail_count++;
          end
          if (rsp.worker_opened !== want.opened) begin
            $error("worker_opened: expected %0d, got %0d", want.opened, rsp.worker_opened);
            fail_count++;
          end
          if (rsp.worker_retired !== want.retired) begin
            $error("worker_retired: expected %0d, got %0d", want.retired, rsp.worker_retired);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        pending_outcomes.push_back(assign_or_release(req.req_type, req.object_key));
      end
    end
    open_items <= pending_outcomes.size();
  end

endmodule

// File: bench/least_loaded_worker_assigner_core_test.sv
`timescale 1ns / 100ps

module least_loaded_worker_assigner_core_test;
  import llwa_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RSP_HOLD    = 600;
  localparam int POOL_SIZE   = 96;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [MAXW_BITS-1:0] cfg_wdata;
  int                   fail_count;
  int                   open_items;
  int                   cycle_count = 0;
  bit                   hold_rsp = 1'b0;
  int                   send_calm = 0;
  int                   take_calm = 0;

  logic [KEY_FIELD_BITS-1:0] key_pool [POOL_SIZE];
  logic [KEY_FIELD_BITS-1:0] assigned_keys [$];
  logic [MAXW_BITS-1:0]      cap_plan [PHASES] = '{8, 1, 0, 15, 2, 5, 3, 8, 7, 6};
  int                        assign_share [PHASES] = '{85, 50, 70, 40, 80, 55, 30, 75, 60, 50};
  int                        pool_span [PHASES] = '{96, 16, 40, 96, 12, 40, 96, 24, 64, 8};

  llwa_req_if req_ch ();
  llwa_rsp_if rsp_ch ();

  least_loaded_worker_assigner_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  least_loaded_worker_assigner_monitor outcome_monitor (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .open_items (open_items)
  );

  always #2 clk = ~clk;

  task automatic send_request(input logic kind, input logic [KEY_FIELD_BITS-1:0] key);
    int gap;
    if (send_calm == 0 && $urandom_range(0, 29) == 0) send_calm = $urandom_range(10, 40);
    if (send_calm != 0) begin
      gap = 0;
      send_calm--;
    end else begin
      gap = $urandom_range(0, 5);
    end
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.object_key <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (kind == REQ_ASSIGN && key != '0) assigned_keys.push_back(key);
  endtask

  // Stops offering and waits until every expected result has been taken.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (open_items != 0);
  endtask

  task automatic write_worker_cap(input logic [MAXW_BITS-1:0] cap);
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_request(input int share, input int span);
    logic                      kind;
    logic [KEY_FIELD_BITS-1:0] key;
    int                        roll;
    int                        idx;
    kind = ($urandom_range(0, 99) < share) ? REQ_ASSIGN : REQ_RELEASE;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      key = '0;
    end else if (roll < 10) begin
      key = $urandom;
    end else if (kind == REQ_RELEASE && assigned_keys.size() != 0) begin
      idx = $urandom_range(0, assigned_keys.size() - 1);
      key = assigned_keys[idx];
      assigned_keys.delete(idx);
    end else begin
      key = key_pool[$urandom_range(0, span - 1)];
    end
    send_request(kind, key);
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_ASSIGN;
    req_ch.object_key <= '0;
    rsp_ch.ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
      if (key_pool[i] == '0) key_pool[i] = 32'd1;
    end
    key_pool[0] = 32'h0000_0001;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset limit of four workers.
    send_request(REQ_ASSIGN, 32'h0000_0000);
    send_request(REQ_RELEASE, 32'h0000_0000);
    send_request(REQ_RELEASE, 32'h0000_0007);
    send_request(REQ_ASSIGN, 32'h0000_0001);
    send_request(REQ_ASSIGN, 32'h0000_0001);
    send_request(REQ_ASSIGN, 32'hFFFF_FFFF);
    send_request(REQ_ASSIGN, 32'h8000_0000);
    send_request(REQ_ASSIGN, 32'h5555_5555);
    send_request(REQ_ASSIGN, 32'hAAAA_AAAA);
    send_request(REQ_ASSIGN, 32'h1234_5678);
    send_request(REQ_RELEASE, 32'h0000_0001);
    send_request(REQ_RELEASE, 32'hAAAA_AAAA);
    send_request(REQ_ASSIGN, 32'h0000_0002);
    send_request(REQ_RELEASE, 32'hFFFF_FFFF);
    send_request(REQ_RELEASE, 32'hFFFF_FFFF);
    send_request(REQ_RELEASE, 32'h0000_0007);

    // Fill the object table past its capacity, then empty those entries again.
    for (int i = 0; i < 70; i++) send_request(REQ_ASSIGN, 32'h5A00_0000 + i);
    for (int i = 0; i < 70; i++) send_request(REQ_RELEASE, 32'h5A00_0000 + i);
    drain_results();

    // The table is kept across phases, so a lowered limit meets more active workers.
    for (int p = 0; p < PHASES; p++) begin
      write_worker_cap(cap_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 40) hold_rsp = 1'b1;
        if (p == 5 && n == 100) drain_results();
        send_random_request(assign_share[p], pool_span[p]);
      end
      drain_results();
    end

    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random gaps, calm stretches, and one long hold-off.
  initial begin
    int gap;
    int hold_left;
    wait (!rst);
    forever begin
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        hold_left = RSP_HOLD;
        while (hold_left != 0) begin
          @(posedge clk);
          hold_left--;
        end
        hold_rsp = 1'b0;
      end else begin
        if (take_calm == 0 && $urandom_range(0, 29) == 0) take_calm = $urandom_range(10, 40);
        if (take_calm != 0) begin
          gap = 0;
          take_calm--;
        end else begin
          gap = $urandom_range(0, 5);
        end
        if (gap != 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
